// ----- rtl/countdown_display_and_redraw_defines.svh -----
// Assertion helpers shared by the RTL files.
`ifndef COUNTDOWN_DISPLAY_AND_REDRAW_DEFINES_SVH
`define COUNTDOWN_DISPLAY_AND_REDRAW_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define CDR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define CDR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/cdr_pkg.sv -----
`default_nettype none
package cdr_pkg;

   localparam int SEC_W   = 33;
   localparam int MS_W    = 48;
   localparam int TOT_W   = 32;
   localparam int UNIT_W  = 3;
   localparam int VAL_W   = 7;
   localparam int FRAC_W  = 17;
   localparam int DELAY_W = 27;
   localparam int UMS_W   = 27;
   localparam int VDIV_W  = 17;
   localparam int Q_W     = TOT_W + 10;
   localparam int DW      = 48;
   localparam int DIV_CNT_W = $clog2(DW);

   localparam int ARC_STEPS = 256;
   localparam int FRAC_FULL  = 4096;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [UNIT_W-1:0] UNIT_SEC  = 3'd0;
   localparam logic [UNIT_W-1:0] UNIT_MIN  = 3'd1;
   localparam logic [UNIT_W-1:0] UNIT_HOUR = 3'd2;
   localparam logic [UNIT_W-1:0] UNIT_DAY  = 3'd3;
   localparam logic [UNIT_W-1:0] UNIT_INF  = 3'd4;

   localparam logic [TOT_W-1:0]  SEC_DAY  = 32'd86400;
   localparam logic [TOT_W-1:0]  SEC_HOUR = 32'd3600;
   localparam logic [TOT_W-1:0]  SEC_MIN  = 32'd60;
   localparam logic [UMS_W-1:0]  MS_DAY   = 27'd86400000;
   localparam logic [UMS_W-1:0]  MS_HOUR  = 27'd3600000;
   localparam logic [UMS_W-1:0]  MS_MIN   = 27'd60000;
   localparam logic [UMS_W-1:0]  MS_SEC   = 27'd1000;
   localparam logic [Q_W-1:0]    Q_MIN    = 42'd1000;
   localparam logic [VAL_W-1:0]  VAL_MAX  = 7'd99;
   localparam logic [DELAY_W-1:0] DELAY_MIN = 27'd200;
   localparam logic [DELAY_W-1:0] DELAY_PAD = 27'd20;
   localparam logic [DELAY_W-1:0] DELAY_INF = 27'd3600000;

   // Classified work handed from front to back
   typedef struct packed {
      logic                inf;
      logic                expired;
      logic [UNIT_W-1:0]   unit;
      logic [VDIV_W-1:0]   vdiv;
      logic [TOT_W-1:0]    r;
      logic [TOT_W-1:0]    total;
      logic [MS_W-2:0]     rms;
      logic [UMS_W-1:0]    unit_ms;
      logic [Q_W-1:0]      q;
   } work_type;

endpackage
`default_nettype wire

// ----- rtl/cdr_if.sv -----
`default_nettype none
interface cdr_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [cdr_pkg::SEC_W-1:0]    remaining_seconds;
   logic signed [cdr_pkg::MS_W-1:0]     remaining_millis;

   modport source (output valid, remaining_seconds, remaining_millis, input ready);
   modport sink   (input valid, remaining_seconds, remaining_millis, output ready);
endinterface

interface cdr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cdr_pkg::UNIT_W-1:0]          display_unit;
   logic [cdr_pkg::VAL_W-1:0]           display_value;
   logic [cdr_pkg::FRAC_W-1:0]          arc_fraction;
   logic [cdr_pkg::DELAY_W-1:0]         next_change_delay;

   modport source (output valid, display_unit, display_value, arc_fraction,
                   next_change_delay, input ready);
   modport sink   (input valid, display_unit, display_value, arc_fraction,
                   next_change_delay, output ready);
endinterface
`default_nettype wire

// ----- rtl/countdown_display_and_redraw.sv -----
// Countdown display and redraw scheduler. Each request beat carries the time left in
// seconds and in milliseconds; the response beat gives the display unit and value, the
// arc fraction and the delay until the next redraw, computed against the duration held
// in the csr register (zero means no timer). The front end classifies a beat in the
// cycle it is accepted and places it in a two-entry queue, so requests keep flowing
// while the back end works. The back end runs four 48-step shift-subtract dividers side
// by side, then sees them done in ST_RUN, picks the boundary in ST_FIN, loads the output
// register in ST_HOLD and pops the next entry from ST_IDLE. It takes no new entry until
// the last is loaded, and the load waits while an untaken beat holds the output register;
// the divider length sets the sustained rate. A finished result sits in an output
// register while the next item is being computed. Write csr only while the block is idle.
`default_nettype none
module countdown_display_and_redraw (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [cdr_pkg::TOT_W-1:0]   csr_wdata,
   cdr_req_if.sink                          req_bus,
   cdr_rsp_if.source                        rsp_bus
);

   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;
   cdr_pkg::work_type  push_data;
   cdr_pkg::work_type  head;

   cdr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   cdr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   cdr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule
`default_nettype wire

// ----- rtl/cdr_front.sv -----
`default_nettype none
module cdr_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [cdr_pkg::TOT_W-1:0]   csr_wdata,
   cdr_req_if.sink                          req,
   input  wire logic                        q_full,
   output logic                             push,
   output cdr_pkg::work_type                push_data
);

   logic [cdr_pkg::TOT_W-1:0] total_ff;
   logic [cdr_pkg::TOT_W-1:0] total_in;
   logic [cdr_pkg::TOT_W-1:0] r_pos;
   logic [cdr_pkg::MS_W-2:0]  rms;
   logic [cdr_pkg::Q_W-1:0]   q_prod;
   logic [cdr_pkg::Q_W-1:0]   q_raw;

   // Hold the duration register
   assign total_in = csr_we ? csr_wdata : total_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign req.ready = !q_full;
   assign push      = req.valid && req.ready;

   // Clamp seconds into 0..total
   always_comb begin
      r_pos = req.remaining_seconds[cdr_pkg::TOT_W-1:0];
      if (req.remaining_seconds[cdr_pkg::SEC_W-1]) begin
         r_pos = '0;
      end else if (r_pos > total_ff) begin
         r_pos = total_ff;
      end
   end

   assign rms    = req.remaining_millis[cdr_pkg::MS_W-2:0];
   assign q_prod = cdr_pkg::Q_W'(total_ff) * cdr_pkg::Q_W'(1000);
   assign q_raw  = q_prod / cdr_pkg::ARC_STEPS;

   // Classify the beat
   always_comb begin
      push_data.inf     = (total_ff == '0);
      push_data.expired = req.remaining_millis[cdr_pkg::MS_W-1] ||
                          (req.remaining_millis == '0);
      push_data.r       = r_pos;
      push_data.total   = total_ff;
      push_data.rms     = rms;
      push_data.q       = (q_raw < cdr_pkg::Q_MIN) ? cdr_pkg::Q_MIN : q_raw;
      if (r_pos >= cdr_pkg::SEC_DAY) begin
         push_data.unit = cdr_pkg::UNIT_DAY;
         push_data.vdiv = cdr_pkg::VDIV_W'(cdr_pkg::SEC_DAY);
      end else if (r_pos >= cdr_pkg::SEC_HOUR) begin
         push_data.unit = cdr_pkg::UNIT_HOUR;
         push_data.vdiv = cdr_pkg::VDIV_W'(cdr_pkg::SEC_HOUR);
      end else if (r_pos >= cdr_pkg::SEC_MIN) begin
         push_data.unit = cdr_pkg::UNIT_MIN;
         push_data.vdiv = cdr_pkg::VDIV_W'(cdr_pkg::SEC_MIN);
      end else begin
         push_data.unit = cdr_pkg::UNIT_SEC;
         push_data.vdiv = cdr_pkg::VDIV_W'(1);
      end
      if (rms >= (cdr_pkg::MS_W-1)'(cdr_pkg::MS_DAY)) begin
         push_data.unit_ms = cdr_pkg::MS_DAY;
      end else if (rms >= (cdr_pkg::MS_W-1)'(cdr_pkg::MS_HOUR)) begin
         push_data.unit_ms = cdr_pkg::MS_HOUR;
      end else if (rms >= (cdr_pkg::MS_W-1)'(cdr_pkg::MS_MIN)) begin
         push_data.unit_ms = cdr_pkg::MS_MIN;
      end else begin
         push_data.unit_ms = cdr_pkg::MS_SEC;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/cdr_fifo.sv -----
`default_nettype none
`include "countdown_display_and_redraw_defines.svh"
module cdr_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cdr_pkg::work_type push_data,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output cdr_pkg::work_type      head
);

   cdr_pkg::work_type               slot_ff [cdr_pkg::QDEPTH];
   logic [cdr_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [cdr_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [cdr_pkg::QPTR_W:0]        count_ff;

   assign full  = (count_ff == (cdr_pkg::QPTR_W+1)'(cdr_pkg::QDEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `CDR_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !empty)
   `CDR_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !empty)

endmodule
`default_nettype wire

// ----- rtl/cdr_div.sv -----
`default_nettype none
module cdr_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [cdr_pkg::DW-1:0]  dividend,
   input  wire logic [cdr_pkg::DW-1:0]  divisor,
   output logic                         busy,
   output logic [cdr_pkg::DW-1:0]       quotient,
   output logic [cdr_pkg::DW-1:0]       remainder
);

   logic [cdr_pkg::DW-1:0]        quo_ff;
   logic [cdr_pkg::DW-1:0]        rem_ff;
   logic [cdr_pkg::DW-1:0]        dvs_ff;
   logic [cdr_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic [cdr_pkg::DW:0]          rem_sh;
   logic [cdr_pkg::DW:0]          rem_sub;
   logic                          ge;

   // One restoring step per cycle
   assign rem_sh  = {rem_ff, quo_ff[cdr_pkg::DW-1]};
   assign ge      = (rem_sh >= {1'b0, dvs_ff});
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= cdr_pkg::DIV_CNT_W'(cdr_pkg::DW-1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[cdr_pkg::DW-2:0], ge};
         rem_ff <= ge ? rem_sub[cdr_pkg::DW-1:0] : rem_sh[cdr_pkg::DW-1:0];
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ----- rtl/cdr_back.sv -----
`default_nettype none
`include "countdown_display_and_redraw_defines.svh"
module cdr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire cdr_pkg::work_type head,
   output logic                   pop,
   cdr_rsp_if.source              rsp
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN, ST_HOLD} state_type;

   state_type                       state_ff;
   cdr_pkg::work_type               cur_ff;
   logic [cdr_pkg::UMS_W-1:0]       near_ff;
   logic [cdr_pkg::VAL_W-1:0]       val_ff;
   logic [cdr_pkg::FRAC_W-1:0]      frac_ff;
   logic                            out_valid_ff;
   logic [cdr_pkg::UNIT_W-1:0]      out_unit_ff;
   logic [cdr_pkg::VAL_W-1:0]       out_val_ff;
   logic [cdr_pkg::FRAC_W-1:0]      out_frac_ff;
   logic [cdr_pkg::DELAY_W-1:0]     out_delay_ff;

   logic                            start;
   logic                            load;
   logic [3:0]                      busy;
   logic [cdr_pkg::DW-1:0]          dvd [4];
   logic [cdr_pkg::DW-1:0]          dvs [4];
   logic [cdr_pkg::DW-1:0]          quo [4];
   logic [cdr_pkg::DW-1:0]          rem [4];
   logic [cdr_pkg::DW-1:0]          to_unit;
   logic [cdr_pkg::DW-1:0]          to_frac;
   logic [cdr_pkg::DW-1:0]          near_w;
   logic [cdr_pkg::DW-1:0]          frac_w;
   logic [cdr_pkg::DW-1:0]          capped;
   logic [cdr_pkg::DW-1:0]          padded;
   logic [cdr_pkg::DELAY_W-1:0]     delay;

   assign start = (state_ff == ST_IDLE) && !q_empty;
   assign pop   = start;
   assign load  = (state_ff == ST_HOLD) && (!out_valid_ff || rsp.ready);

   // Feed the four dividers from the queue head
   assign dvd[0] = cdr_pkg::DW'(head.r);
   assign dvs[0] = cdr_pkg::DW'(head.vdiv);
   assign dvd[1] = cdr_pkg::DW'(head.r) * cdr_pkg::DW'(cdr_pkg::ARC_STEPS);
   assign dvs[1] = cdr_pkg::DW'(head.total);
   assign dvd[2] = cdr_pkg::DW'(head.rms);
   assign dvs[2] = cdr_pkg::DW'(head.unit_ms);
   assign dvd[3] = cdr_pkg::DW'(head.rms);
   assign dvs[3] = cdr_pkg::DW'(head.q);

   for (genvar i = 0; i < 4; i++) begin : g_div
      cdr_div u_div (
         .clock     (clock),
         .reset     (reset),
         .start     (start),
         .dividend  (dvd[i]),
         .divisor   (dvs[i]),
         .busy      (busy[i]),
         .quotient  (quo[i]),
         .remainder (rem[i])
      );
   end

   // Pick the nearer boundary and scale the arc
   always_comb begin
      to_unit = (rem[2] == '0) ? cdr_pkg::DW'(cur_ff.unit_ms) : rem[2];
      to_frac = (rem[3] == '0) ? cdr_pkg::DW'(cur_ff.q) : rem[3];
      near_w  = (to_unit < to_frac) ? to_unit : to_frac;
      frac_w  = (quo[1] * cdr_pkg::DW'(cdr_pkg::FRAC_FULL)) / cdr_pkg::ARC_STEPS;
   end

   // Cap at the time left, pad and floor the delay; with no timer use DELAY_INF
   always_comb begin
      capped = (cdr_pkg::DW'(near_ff) > cdr_pkg::DW'(cur_ff.rms)) ?
               cdr_pkg::DW'(cur_ff.rms) : cdr_pkg::DW'(near_ff);
      padded = capped + cdr_pkg::DW'(cdr_pkg::DELAY_PAD);
      if (cur_ff.inf) begin
         delay = cdr_pkg::DELAY_INF;
      end else if (cur_ff.expired || (padded < cdr_pkg::DW'(cdr_pkg::DELAY_MIN))) begin
         delay = cdr_pkg::DELAY_MIN;
      end else begin
         delay = padded[cdr_pkg::DELAY_W-1:0];
      end
   end

   // Sequence one item and hold the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cur_ff   <= head;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (busy == '0) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               near_ff  <= near_w[cdr_pkg::UMS_W-1:0];
               val_ff   <= (quo[0] > cdr_pkg::DW'(cdr_pkg::VAL_MAX)) ?
                           cdr_pkg::VAL_MAX : quo[0][cdr_pkg::VAL_W-1:0];
               frac_ff  <= frac_w[cdr_pkg::FRAC_W-1:0];
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (load) begin
                  out_unit_ff  <= cur_ff.inf ? cdr_pkg::UNIT_INF : cur_ff.unit;
                  out_val_ff   <= cur_ff.inf ? '0 : val_ff;
                  out_frac_ff  <= cur_ff.inf ? cdr_pkg::FRAC_W'(cdr_pkg::FRAC_FULL) : frac_ff;
                  out_delay_ff <= delay;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.display_unit      = out_unit_ff;
   assign rsp.display_value     = out_val_ff;
   assign rsp.arc_fraction      = out_frac_ff;
   assign rsp.next_change_delay = out_delay_ff;

   `CDR_ASSERT_NEXT(a_div_start, clock, reset, start, busy == 4'hF)
   `CDR_ASSERT_IMPL(a_delay_floor, clock, reset, out_valid_ff, out_delay_ff >= cdr_pkg::DELAY_MIN)

endmodule
`default_nettype wire
